>>> hdl/rect_polygon_clipper_assert.svh
// Assertion macros used by the clipper checker.
`ifndef RECT_POLYGON_CLIPPER_ASSERT_SVH
`define RECT_POLYGON_CLIPPER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rect_polygon_clipper check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define RPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rect_polygon_clipper check failed");

`endif

>>> hdl/rpc_pkg.sv
// Types, constants and helpers of the rectangle polygon clipper.
`default_nettype none
package rpc_pkg;

    localparam int COORD_BITS   = 10;
    localparam int NUM_STAGES   = 4;
    localparam int MAX_RESULTS  = 32;
    localparam int CNT_BITS     = $clog2(MAX_RESULTS + 1);
    localparam int PROD_BITS    = 2 * COORD_BITS + 3;
    localparam int QUO_BITS     = 2 * COORD_BITS + 2;
    localparam int DIV_CNT_BITS = $clog2(QUO_BITS);
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 32;

    typedef logic [COORD_BITS-1:0] t_coord;

    localparam t_coord COORD_MAX = '1;

    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_Y_MIN = 2'd1;
    localparam logic [1:0] REG_X_MAX = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    typedef enum logic [1:0] {
        TK_VTX,
        TK_END,
        TK_CLOSE
    } t_kind;

    typedef struct packed {
        t_kind  kind;
        t_coord x;
        t_coord y;
    } t_tok;

    typedef struct packed {
        t_coord bound;
        logic   vert;
        logic   below;
    } t_bnd;

    typedef struct packed {
        t_coord vertex_x;
        t_coord vertex_y;
        logic   closes_polygon;
    } t_in;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        logic   vertex_present;
        logic   end_of_polygon;
    } t_out;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_EVAL,
        CS_MUL1,
        CS_MUL2,
        CS_NORM,
        CS_DIV,
        CS_EMIT_I,
        CS_EMIT_E,
        CS_EMIT_M
    } t_cell_state;

    function automatic logic f_inside(t_coord b, t_coord bnd, logic below);
        return below ? (b < bnd) : (b > bnd);
    endfunction

endpackage
`default_nettype wire

>>> hdl/rpc_cell.sv
// One boundary cell: clips the token stream against one window edge.
`default_nettype none
module rpc_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rpc_pkg::t_bnd i_bnd,
    input  logic          i_tok_valid,
    input  rpc_pkg::t_tok i_tok,
    output logic          o_tok_ready,
    output logic          o_out_valid,
    output rpc_pkg::t_tok o_out_tok,
    input  logic          i_out_ready
);
    import rpc_pkg::*;

    t_cell_state r_state, n_state;
    t_coord      r_fx, r_fy, r_px, r_py, r_sx, r_sy, r_ex, r_ey;
    logic        r_has, r_pend;
    t_kind       r_mark;
    logic signed [PROD_BITS-1:0] r_acc;
    logic [QUO_BITS-1:0]         r_num, r_quo;
    t_coord                      r_den, r_rem;
    logic [DIV_CNT_BITS-1:0]     r_cnt;

    t_coord s_a, s_b, e_a, e_b, w_q;
    logic   s_in, e_in, w_ge;
    logic signed [COORD_BITS:0]     w_d, w_da, w_db, w_dm;
    logic signed [2*COORD_BITS+1:0] w_p1, w_p2;
    logic signed [PROD_BITS-1:0]    w_n;
    logic [COORD_BITS:0]            w_rsh, w_rsub;
    t_cell_state                    w_done;

    // a runs along the boundary, b across it
    assign s_a  = i_bnd.vert ? r_sy : r_sx;
    assign s_b  = i_bnd.vert ? r_sx : r_sy;
    assign e_a  = i_bnd.vert ? r_ey : r_ex;
    assign e_b  = i_bnd.vert ? r_ex : r_ey;
    assign s_in = f_inside(s_b, i_bnd.bound, i_bnd.below);
    assign e_in = f_inside(e_b, i_bnd.bound, i_bnd.below);

    assign w_d  = $signed({1'b0, e_b}) - $signed({1'b0, s_b});
    assign w_da = $signed({1'b0, e_a}) - $signed({1'b0, s_a});
    assign w_db = $signed({1'b0, i_bnd.bound}) - $signed({1'b0, s_b});
    assign w_p1 = $signed({1'b0, s_a}) * w_d;
    assign w_p2 = w_da * w_db;
    assign w_n  = w_d[COORD_BITS] ? -r_acc : r_acc;
    assign w_dm = w_d[COORD_BITS] ? -w_d : w_d;

    assign w_rsh  = {r_rem, r_num[QUO_BITS-1]};
    assign w_ge   = w_rsh >= {1'b0, r_den};
    assign w_rsub = w_rsh - {1'b0, r_den};
    assign w_q    = (|r_quo[QUO_BITS-1:COORD_BITS]) ? COORD_MAX : r_quo[COORD_BITS-1:0];

    assign w_done = r_pend ? CS_EMIT_M : CS_IDLE;

    always_comb begin
        n_state = r_state;
        case (r_state)
            CS_IDLE: begin
                if (i_tok_valid) begin
                    case (i_tok.kind)
                        TK_VTX:   n_state = r_has ? CS_EVAL : CS_IDLE;
                        TK_CLOSE: n_state = r_has ? CS_EVAL : CS_EMIT_M;
                        default:  n_state = CS_EMIT_M;
                    endcase
                end
            end
            CS_EVAL: begin
                if (s_in && e_in) begin
                    n_state = CS_EMIT_E;
                end else if (!s_in && !e_in) begin
                    n_state = w_done;
                end else begin
                    n_state = CS_MUL1;
                end
            end
            CS_MUL1: n_state = CS_MUL2;
            CS_MUL2: n_state = CS_NORM;
            CS_NORM: n_state = w_n[PROD_BITS-1] ? CS_EMIT_I : CS_DIV;
            CS_DIV: begin
                if (r_cnt == '0) begin
                    n_state = CS_EMIT_I;
                end
            end
            CS_EMIT_I: begin
                if (i_out_ready) begin
                    n_state = e_in ? CS_EMIT_E : w_done;
                end
            end
            CS_EMIT_E: begin
                if (i_out_ready) begin
                    n_state = w_done;
                end
            end
            CS_EMIT_M: begin
                if (i_out_ready) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_tok_ready    = 1'b0;
        o_out_valid    = 1'b0;
        o_out_tok.kind = TK_VTX;
        o_out_tok.x    = r_ex;
        o_out_tok.y    = r_ey;
        case (r_state)
            CS_IDLE: o_tok_ready = 1'b1;
            CS_EMIT_I: begin
                o_out_valid = 1'b1;
                o_out_tok.x = i_bnd.vert ? i_bnd.bound : w_q;
                o_out_tok.y = i_bnd.vert ? w_q : i_bnd.bound;
            end
            CS_EMIT_E: o_out_valid = 1'b1;
            CS_EMIT_M: begin
                o_out_valid    = 1'b1;
                o_out_tok.kind = r_mark;
            end
            default: o_out_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_has   <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == CS_IDLE && i_tok_valid) begin
                case (i_tok.kind)
                    TK_VTX: begin
                        r_has  <= 1'b1;
                        r_pend <= 1'b0;
                    end
                    TK_CLOSE: begin
                        r_has  <= 1'b0;
                        r_pend <= 1'b1;
                    end
                    default: r_pend <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            CS_IDLE: begin
                if (i_tok_valid) begin
                    r_mark <= i_tok.kind;
                    case (i_tok.kind)
                        TK_VTX: begin
                            if (!r_has) begin
                                r_fx <= i_tok.x;
                                r_fy <= i_tok.y;
                            end
                            r_sx <= r_px;
                            r_sy <= r_py;
                            r_ex <= i_tok.x;
                            r_ey <= i_tok.y;
                            r_px <= i_tok.x;
                            r_py <= i_tok.y;
                        end
                        TK_CLOSE: begin
                            // wrap edge: previous back to first
                            r_sx <= r_px;
                            r_sy <= r_py;
                            r_ex <= r_fx;
                            r_ey <= r_fy;
                        end
                        default: r_ex <= r_ex;
                    endcase
                end
            end
            CS_MUL1: r_acc <= PROD_BITS'(w_p1);
            CS_MUL2: r_acc <= r_acc + PROD_BITS'(w_p2);
            CS_NORM: begin
                r_num <= w_n[QUO_BITS-1:0];
                r_den <= w_dm[COORD_BITS-1:0];
                r_rem <= '0;
                r_cnt <= DIV_CNT_BITS'(QUO_BITS - 1);
                r_quo <= '0;
            end
            CS_DIV: begin
                r_rem <= w_ge ? w_rsub[COORD_BITS-1:0] : w_rsh[COORD_BITS-1:0];
                r_num <= {r_num[QUO_BITS-2:0], 1'b0};
                r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/rpc_collect.sv
// Result collector: caps results per request, tags the last one, drives output register.
`default_nettype none
module rpc_collect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tok_valid,
    input  rpc_pkg::t_tok i_tok,
    output logic          o_tok_ready,
    output logic          o_out_valid,
    output rpc_pkg::t_out o_out_data,
    input  logic          i_out_ready
);
    import rpc_pkg::*;

    logic                r_out_v, r_hold_v;
    t_out                r_out;
    t_coord              r_hx, r_hy;
    logic [CNT_BITS-1:0] r_cnt;

    logic w_free, w_full, w_acc, w_keep, w_load;
    t_out w_load_data;

    assign w_free = !r_out_v || i_out_ready;
    assign w_full = r_cnt == CNT_BITS'(MAX_RESULTS);

    always_comb begin
        case (i_tok.kind)
            TK_VTX:   o_tok_ready = w_full || !r_hold_v || w_free;
            TK_END:   o_tok_ready = !r_hold_v || w_free;
            TK_CLOSE: o_tok_ready = w_free;
            default:  o_tok_ready = 1'b1;
        endcase
    end

    assign w_acc  = i_tok_valid && o_tok_ready;
    // a vertex beyond the cap is dropped
    assign w_keep = w_acc && i_tok.kind == TK_VTX && !w_full;
    assign w_load = w_acc && ((w_keep && r_hold_v)
                           || (i_tok.kind == TK_END && r_hold_v)
                           || i_tok.kind == TK_CLOSE);

    assign w_load_data.out_x          = r_hold_v ? r_hx : '0;
    assign w_load_data.out_y          = r_hold_v ? r_hy : '0;
    assign w_load_data.vertex_present = r_hold_v;
    assign w_load_data.end_of_polygon = i_tok.kind == TK_CLOSE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (w_keep) begin
                r_hold_v <= 1'b1;
                r_cnt    <= r_cnt + 1'b1;
            end else if (w_acc && i_tok.kind != TK_VTX) begin
                r_hold_v <= 1'b0;
                r_cnt    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_load_data;
        end
        if (w_keep) begin
            r_hx <= i_tok.x;
            r_hy <= i_tok.y;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> hdl/rect_polygon_clipper.sv
// Top level of the rectangle polygon clipper: config registers, feeder, cell row, collector.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+----------------------------
//   vertex   | in  | i_in_valid / o_in_ready    | i_in_data  (t_in)
//   result   | out | o_out_valid / i_out_ready  | o_out_data (t_out)
//   config   | in  | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Each request becomes a vertex token and a marker token that run through four
// boundary cells in turn. A cell evaluates an edge with no crossing directly;
// on a crossing it also multiplies, normalises and runs its bit-serial
// divider, which resolves the intersection one quotient bit a cycle. Cells
// overlap, so the slowest cell and result stalls set the rate. Synchronous
// active-low reset clears control state; stalled results hold in the output register.
`default_nettype none
module rect_polygon_clipper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  rpc_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rpc_pkg::t_out                      o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rpc_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [rpc_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [rpc_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready
);
    import rpc_pkg::*;

    t_coord r_x_min, r_y_min, r_x_max, r_y_max;
    logic   r_feed_v, r_feed_ph;
    t_in    r_feed;

    t_bnd   w_bnd [NUM_STAGES];
    t_tok   w_tok [NUM_STAGES+1];
    logic   w_v   [NUM_STAGES+1];
    logic   w_r   [NUM_STAGES+1];
    t_coord w_rd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_y_min <= '0;
            r_x_max <= COORD_MAX;
            r_y_max <= COORD_MAX;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_X_MIN: r_x_min <= pwdata[COORD_BITS-1:0];
                REG_Y_MIN: r_y_min <= pwdata[COORD_BITS-1:0];
                REG_X_MAX: r_x_max <= pwdata[COORD_BITS-1:0];
                REG_Y_MAX: r_y_max <= pwdata[COORD_BITS-1:0];
                default:   r_x_min <= r_x_min;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_X_MIN: w_rd = r_x_min;
            REG_Y_MIN: w_rd = r_y_min;
            REG_X_MAX: w_rd = r_x_max;
            REG_Y_MAX: w_rd = r_y_max;
            default:   w_rd = '0;
        endcase
    end
    assign prdata = PDATA_BITS'(w_rd);

    // feed the vertex, then the marker that closes the request
    assign o_in_ready = !r_feed_v;
    assign w_v[0]     = r_feed_v;
    assign w_tok[0].kind = !r_feed_ph ? TK_VTX : (r_feed.closes_polygon ? TK_CLOSE : TK_END);
    assign w_tok[0].x    = r_feed.vertex_x;
    assign w_tok[0].y    = r_feed.vertex_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_v  <= 1'b0;
            r_feed_ph <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_feed_v  <= 1'b1;
            r_feed_ph <= 1'b0;
        end else if (w_v[0] && w_r[0]) begin
            r_feed_ph <= 1'b1;
            if (r_feed_ph) begin
                r_feed_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_feed <= i_in_data;
        end
    end

    // top, right, bottom, left
    assign w_bnd[0] = '{bound: r_y_max, vert: 1'b0, below: 1'b1};
    assign w_bnd[1] = '{bound: r_x_max, vert: 1'b1, below: 1'b1};
    assign w_bnd[2] = '{bound: r_y_min, vert: 1'b0, below: 1'b0};
    assign w_bnd[3] = '{bound: r_x_min, vert: 1'b1, below: 1'b0};

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
        rpc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_bnd       (w_bnd[g]),
            .i_tok_valid (w_v[g]),
            .i_tok       (w_tok[g]),
            .o_tok_ready (w_r[g]),
            .o_out_valid (w_v[g+1]),
            .o_out_tok   (w_tok[g+1]),
            .i_out_ready (w_r[g+1])
        );
    end

    rpc_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_v[NUM_STAGES]),
        .i_tok       (w_tok[NUM_STAGES]),
        .o_tok_ready (w_r[NUM_STAGES]),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
`default_nettype wire

>>> hdl/rpc_check.sv
// Port-level checker for the clipper, bound to the top level.
`default_nettype none
`include "rect_polygon_clipper_assert.svh"
module rpc_check (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input rpc_pkg::t_in                   i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input rpc_pkg::t_out                  o_out_data,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [rpc_pkg::PADDR_BITS-1:0] paddr,
    input logic [rpc_pkg::PDATA_BITS-1:0] pwdata,
    input logic [rpc_pkg::PDATA_BITS-1:0] prdata,
    input logic                           pready
);
    import rpc_pkg::*;

    `RPC_ASSERT_IMP(a_pready_high, 1'b1, pready)
    `RPC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `RPC_ASSERT_IMP(a_empty_is_end, o_out_valid && !o_out_data.vertex_present, o_out_data.end_of_polygon && o_out_data.out_x == '0 && o_out_data.out_y == '0)
    `RPC_ASSERT_IMP(a_prdata_narrow, 1'b1, prdata[PDATA_BITS-1:COORD_BITS] == '0)

endmodule

bind rect_polygon_clipper rpc_check u_rpc_check (.*);
`default_nettype wire
